// ----- hw/rtl/tcw_pkg.sv -----
// tcw_pkg: shared widths, command and register codes, and the structs
// passed between the console cell writer's modules. No dependencies.
package tcw_pkg;

    localparam int COL_W     = 7;
    localparam int ROW_W     = 5;
    localparam int CHAR_W    = 8;
    localparam int COLOR_W   = 4;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 7;
    localparam int CELL_W    = CHAR_W + 2 * COLOR_W;

    // input commands
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 3'd4;

    // register reset values
    localparam logic [COL_W-1:0]   RST_COLUMNS    = 7'd80;
    localparam logic [ROW_W-1:0]   RST_ROWS       = 5'd25;
    localparam logic [ROW_W-1:0]   RST_HEADER     = 5'd0;
    localparam logic [COLOR_W-1:0] RST_FOREGROUND = 4'd15;
    localparam logic [COLOR_W-1:0] RST_BACKGROUND = 4'd0;

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;

    // datapath operations issued by the controller, one per cycle
    typedef logic [3:0] dp_op_t;
    localparam dp_op_t OP_NOP        = 4'd0;
    localparam dp_op_t OP_LATCH      = 4'd1;
    localparam dp_op_t OP_CLAMP      = 4'd2;
    localparam dp_op_t OP_DIV        = 4'd3;
    localparam dp_op_t OP_SET        = 4'd4;
    localparam dp_op_t OP_CLR_INIT   = 4'd5;
    localparam dp_op_t OP_CLR_WR     = 4'd6;
    localparam dp_op_t OP_RD_ISSUE   = 4'd7;
    localparam dp_op_t OP_SCR_INIT   = 4'd8;
    localparam dp_op_t OP_SCR_RD     = 4'd9;
    localparam dp_op_t OP_SCR_WR     = 4'd10;
    localparam dp_op_t OP_BLANK_INIT = 4'd11;
    localparam dp_op_t OP_BLANK_WR   = 4'd12;
    localparam dp_op_t OP_PUT_WR     = 4'd13;
    localparam dp_op_t OP_LOAD_OUT   = 4'd14;

    // effective configuration
    typedef struct packed {
        logic [COL_W-1:0]   ncol;
        logic [ROW_W-1:0]   nrow;
        logic [ROW_W-1:0]   hdr;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        logic               geom_wr;
    } cfg_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             dirty;
        logic             past_end;
        logic             newline;
        logic             wrap;
        logic             last_cell;
        logic             copy_more;
        logic             div_last;
    } dp_status_t;

endpackage

// ----- hw/rtl/tcw_cfg.sv -----
// tcw_cfg: configuration register file and range clamping of its values.
// Depends on tcw_pkg.
module tcw_cfg
    import tcw_pkg::*;
#(
    parameter int MAX_COLUMNS = 80,
    parameter int MAX_ROWS    = 25
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output cfg_t                 cfg
);

    localparam logic [COL_W-1:0] COL_CAP =
        (MAX_COLUMNS > 127) ? 7'd127 : COL_W'(MAX_COLUMNS);
    localparam logic [ROW_W-1:0] ROW_CAP =
        (MAX_ROWS > 31) ? 5'd31 : ROW_W'(MAX_ROWS);

    logic [COL_W-1:0]   columns_reg;
    logic [ROW_W-1:0]   rows_reg;
    logic [ROW_W-1:0]   header_reg;
    logic [COLOR_W-1:0] fg_reg;
    logic [COLOR_W-1:0] bg_reg;
    logic [COL_W-1:0]   ncol;
    logic [ROW_W-1:0]   nrow;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= RST_COLUMNS;
            rows_reg    <= RST_ROWS;
            header_reg  <= RST_HEADER;
            fg_reg      <= RST_FOREGROUND;
            bg_reg      <= RST_BACKGROUND;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_COLUMNS:    columns_reg <= cfg_data;
                CFG_ROWS:       rows_reg    <= cfg_data[ROW_W-1:0];
                CFG_HEADER:     header_reg  <= cfg_data[ROW_W-1:0];
                CFG_FOREGROUND: fg_reg      <= cfg_data[COLOR_W-1:0];
                CFG_BACKGROUND: bg_reg      <= cfg_data[COLOR_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        if (columns_reg == '0)
            ncol = 7'd1;
        else if (columns_reg > COL_CAP)
            ncol = COL_CAP;
        else
            ncol = columns_reg;

        if (rows_reg == '0)
            nrow = 5'd1;
        else if (rows_reg > ROW_CAP)
            nrow = ROW_CAP;
        else
            nrow = rows_reg;
    end

    assign cfg.ncol    = ncol;
    assign cfg.nrow    = nrow;
    // the bottom row always scrolls
    assign cfg.hdr     = (header_reg > nrow - 5'd1) ? nrow - 5'd1 : header_reg;
    assign cfg.fg      = fg_reg;
    assign cfg.bg      = bg_reg;
    assign cfg.geom_wr = cfg_write && (cfg_index == CFG_COLUMNS || cfg_index == CFG_ROWS);

endmodule

// ----- hw/rtl/tcw_ctrl.sv -----
// tcw_ctrl: sequencer that steps the datapath through each command and
// owns the input stall and the result valid. Depends on tcw_pkg.
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    input  dp_status_t status,
    output dp_cmd_t    dp_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_START   = 4'd1;
    localparam logic [3:0] S_DIV     = 4'd2;
    localparam logic [3:0] S_SCR_RD  = 4'd3;
    localparam logic [3:0] S_SCR_WR  = 4'd4;
    localparam logic [3:0] S_BLANK   = 4'd5;
    localparam logic [3:0] S_PUT_WR  = 4'd6;
    localparam logic [3:0] S_CLR     = 4'd7;
    localparam logic [3:0] S_RD_WAIT = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    dp_op_t     op;
    logic       nl_more;

    // a newline keeps filling until the cell in the last column is written
    assign nl_more = status.newline && !status.wrap;

    always_comb
    begin
        state_next     = state_reg;
        op             = OP_NOP;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op         = OP_LATCH;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (status.dirty)
                begin
                    op         = OP_CLAMP;
                    state_next = S_DIV;
                end
                else
                begin
                    case (status.command)
                        CMD_PUT:
                        begin
                            if (status.past_end)
                            begin
                                op         = OP_SCR_INIT;
                                state_next = S_SCR_RD;
                            end
                            else
                            begin
                                op         = OP_PUT_WR;
                                state_next = nl_more ? S_PUT_WR : S_DONE;
                            end
                        end
                        CMD_SET:
                        begin
                            op         = OP_SET;
                            state_next = S_DONE;
                        end
                        CMD_CLEAR:
                        begin
                            op         = OP_CLR_INIT;
                            state_next = S_CLR;
                        end
                        default:
                        begin
                            op         = OP_RD_ISSUE;
                            state_next = S_RD_WAIT;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                op = OP_DIV;
                if (status.div_last)
                    state_next = S_START;
            end
            S_SCR_RD:
            begin
                if (status.copy_more)
                begin
                    op         = OP_SCR_RD;
                    state_next = S_SCR_WR;
                end
                else
                begin
                    op         = OP_BLANK_INIT;
                    state_next = S_BLANK;
                end
            end
            S_SCR_WR:
            begin
                op         = OP_SCR_WR;
                state_next = S_SCR_RD;
            end
            S_BLANK:
            begin
                op = OP_BLANK_WR;
                if (status.last_cell)
                    state_next = S_PUT_WR;
            end
            S_PUT_WR:
            begin
                op = OP_PUT_WR;
                if (!nl_more)
                    state_next = S_DONE;
            end
            S_CLR:
            begin
                op = OP_CLR_WR;
                if (status.last_cell)
                    state_next = S_DONE;
            end
            S_RD_WAIT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    op             = OP_LOAD_OUT;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign dp_cmd.op = op;

endmodule

// ----- hw/rtl/tcw_dp.sv -----
// tcw_dp: cell memory, cursor registers, sweep pointer, row divider and
// result register of the console cell writer. Depends on tcw_pkg.
module tcw_dp
    import tcw_pkg::*;
#(
    parameter int MAX_COLUMNS = 80,
    parameter int MAX_ROWS    = 25
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  dp_cmd_t            dp_cmd,
    output dp_status_t         status,
    input  logic [CMD_W-1:0]   command,
    input  logic [CHAR_W-1:0]  character,
    input  logic [ROW_W-1:0]   row,
    input  logic [COL_W-1:0]   column,
    output logic [ROW_W-1:0]   cursor_row,
    output logic [COL_W-1:0]   cursor_column,
    output logic [CHAR_W-1:0]  cell_character,
    output logic [COLOR_W-1:0] cell_foreground,
    output logic [COLOR_W-1:0] cell_background,
    output logic               scrolled
);

    localparam int MAXC  = (MAX_COLUMNS > 127) ? 127 : MAX_COLUMNS;
    localparam int MAXR  = (MAX_ROWS > 31) ? 31 : MAX_ROWS;
    localparam int DEPTH = MAXC * MAXR;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int MW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = CW + ROW_W;
    localparam int PW    = COL_W + ROW_W;

    logic [CELL_W-1:0] mem [DEPTH];

    // cursor state
    logic [CW-1:0]    idx_reg,   idx_next;
    logic [ROW_W-1:0] crow_reg,  crow_next;
    logic [COL_W-1:0] ccol_reg,  ccol_next;
    logic             dirty_reg, dirty_next;

    // latched command and working registers
    logic [CMD_W-1:0]  cmd_reg,  cmd_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic [ROW_W-1:0]  rin_reg,  rin_next;
    logic [COL_W-1:0]  cin_reg,  cin_next;
    logic [CW-1:0]     ptr_reg,  ptr_next;
    logic [CW-1:0]     rem_reg,  rem_next;
    logic [ROW_W-1:0]  quo_reg,  quo_next;
    logic [2:0]        k_reg,    k_next;
    logic              scr_reg,  scr_next;
    logic [CELL_W-1:0] rdata_reg;

    // result register
    logic [ROW_W-1:0]  orow_reg,  orow_next;
    logic [COL_W-1:0]  ocol_reg,  ocol_next;
    logic [CELL_W-1:0] ocell_reg, ocell_next;
    logic              oscr_reg,  oscr_next;

    // memory ports
    logic              mem_we;
    logic [CW-1:0]     waddr;
    logic [CELL_W-1:0] wdata;
    logic              mem_re;
    logic [CW-1:0]     raddr;

    // geometry
    logic [PW-1:0]     end_prod;
    logic [PW-1:0]     hdr_prod;
    logic [PW-1:0]     set_prod;
    logic [CW-1:0]     ncol_x;
    logic [CW-1:0]     end_x;
    logic [CW-1:0]     hdr_x;
    logic [CW-1:0]     bottom_x;
    logic [ROW_W-1:0]  rin_c;
    logic [COL_W-1:0]  cin_c;
    logic [CW-1:0]     set_addr;
    logic [CW-1:0]     idx_clamped;
    logic [CELL_W-1:0] blank;
    logic [CELL_W-1:0] put_cell;

    // divider step
    logic [DW-1:0]     trial;
    logic              ge;
    logic [CW-1:0]     rem_step;

    assign end_prod = cfg.ncol * cfg.nrow;
    assign hdr_prod = cfg.ncol * cfg.hdr;
    assign ncol_x   = CW'(cfg.ncol);
    assign end_x    = CW'(end_prod);
    assign hdr_x    = CW'(hdr_prod);
    assign bottom_x = end_x - ncol_x;

    assign rin_c    = (rin_reg >= cfg.nrow) ? cfg.nrow - 5'd1 : rin_reg;
    assign cin_c    = (cin_reg >= cfg.ncol) ? cfg.ncol - 7'd1 : cin_reg;
    assign set_prod = PW'(rin_c * cfg.ncol) + PW'(cin_c);
    assign set_addr = CW'(set_prod);

    assign idx_clamped = (idx_reg > end_x) ? end_x : idx_reg;

    assign blank    = {cfg.bg, cfg.fg, CHAR_SPACE};
    assign put_cell = (char_reg == CHAR_NEWLINE) ? blank : {cfg.bg, cfg.fg, char_reg};

    assign trial    = DW'(ncol_x) << k_reg;
    assign ge       = {{ROW_W{1'b0}}, rem_reg} >= trial;
    assign rem_step = ge ? rem_reg - CW'(trial) : rem_reg;

    assign status.command   = cmd_reg;
    assign status.dirty     = dirty_reg;
    assign status.past_end  = (crow_reg == cfg.nrow);
    assign status.newline   = (char_reg == CHAR_NEWLINE);
    assign status.wrap      = (ccol_reg == cfg.ncol - 7'd1);
    assign status.last_cell = ({1'b0, ptr_reg} + 1'b1) == {1'b0, end_x};
    assign status.copy_more = ({1'b0, ptr_reg} + {1'b0, ncol_x}) < {1'b0, end_x};
    assign status.div_last  = (k_reg == '0);

    always_comb
    begin
        idx_next   = idx_reg;
        crow_next  = crow_reg;
        ccol_next  = ccol_reg;
        dirty_next = dirty_reg;
        cmd_next   = cmd_reg;
        char_next  = char_reg;
        rin_next   = rin_reg;
        cin_next   = cin_reg;
        ptr_next   = ptr_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        k_next     = k_reg;
        scr_next   = scr_reg;
        orow_next  = orow_reg;
        ocol_next  = ocol_reg;
        ocell_next = ocell_reg;
        oscr_next  = oscr_reg;
        mem_we     = 1'b0;
        waddr      = ptr_reg;
        wdata      = blank;
        mem_re     = 1'b0;
        raddr      = set_addr;
        case (dp_cmd.op)
            OP_LATCH:
            begin
                cmd_next  = command;
                char_next = character;
                rin_next  = row;
                cin_next  = column;
                scr_next  = 1'b0;
            end
            OP_CLAMP:
            begin
                // pull a cursor left beyond a shrunk grid back to its end
                idx_next = idx_clamped;
                rem_next = idx_clamped;
                quo_next = '0;
                k_next   = 3'(ROW_W - 1);
            end
            OP_DIV:
            begin
                rem_next = rem_step;
                quo_next = {quo_reg[ROW_W-2:0], ge};
                k_next   = k_reg - 3'd1;
                if (k_reg == '0)
                begin
                    crow_next  = {quo_reg[ROW_W-2:0], ge};
                    ccol_next  = COL_W'(rem_step);
                    dirty_next = 1'b0;
                end
            end
            OP_SET:
            begin
                idx_next  = set_addr;
                crow_next = rin_c;
                ccol_next = cin_c;
            end
            OP_CLR_INIT:
            begin
                ptr_next = '0;
            end
            OP_CLR_WR:
            begin
                mem_we   = 1'b1;
                ptr_next = ptr_reg + 1'b1;
            end
            OP_RD_ISSUE:
            begin
                mem_re = 1'b1;
            end
            OP_SCR_INIT:
            begin
                ptr_next = hdr_x;
                scr_next = 1'b1;
            end
            OP_SCR_RD:
            begin
                mem_re = 1'b1;
                raddr  = ptr_reg + ncol_x;
            end
            OP_SCR_WR:
            begin
                mem_we   = 1'b1;
                wdata    = rdata_reg;
                ptr_next = ptr_reg + 1'b1;
            end
            OP_BLANK_INIT:
            begin
                ptr_next = bottom_x;
            end
            OP_BLANK_WR:
            begin
                mem_we   = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                if (status.last_cell)
                begin
                    idx_next  = bottom_x;
                    crow_next = cfg.nrow - 5'd1;
                    ccol_next = '0;
                end
            end
            OP_PUT_WR:
            begin
                mem_we   = 1'b1;
                waddr    = idx_reg;
                wdata    = put_cell;
                idx_next = idx_reg + 1'b1;
                if (status.wrap)
                begin
                    ccol_next = '0;
                    crow_next = crow_reg + 5'd1;
                end
                else
                begin
                    ccol_next = ccol_reg + 7'd1;
                end
            end
            OP_LOAD_OUT:
            begin
                orow_next  = crow_reg;
                ocol_next  = ccol_reg;
                ocell_next = (cmd_reg == CMD_READ) ? rdata_reg : '0;
                oscr_next  = scr_reg;
            end
            default:
            begin
            end
        endcase
        // row and column need recomputing after a geometry change
        if (cfg.geom_wr)
            dirty_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            crow_reg  <= '0;
            ccol_reg  <= '0;
            dirty_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            crow_reg  <= crow_next;
            ccol_reg  <= ccol_next;
            dirty_reg <= dirty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        char_reg  <= char_next;
        rin_reg   <= rin_next;
        cin_reg   <= cin_next;
        ptr_reg   <= ptr_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        k_reg     <= k_next;
        scr_reg   <= scr_next;
        orow_reg  <= orow_next;
        ocol_reg  <= ocol_next;
        ocell_reg <= ocell_next;
        oscr_reg  <= oscr_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr[MW-1:0]] <= wdata;
        if (mem_re)
            rdata_reg <= mem[raddr[MW-1:0]];
    end

    assign cursor_row      = orow_reg;
    assign cursor_column   = ocol_reg;
    assign cell_character  = ocell_reg[CHAR_W-1:0];
    assign cell_foreground = ocell_reg[CHAR_W+COLOR_W-1:CHAR_W];
    assign cell_background = ocell_reg[CELL_W-1:CHAR_W+COLOR_W];
    assign scrolled        = oscr_reg;

endmodule

// ----- hw/rtl/text_console_cell_writer.sv -----
// text_console_cell_writer: top level of the text-mode console engine.
// Depends on tcw_pkg, tcw_cfg, tcw_ctrl and tcw_dp.
//
//  channel   handshake               payload
//  -------   ---------------------   ----------------------------------------
//  command   cmd_valid / cmd_stall   command, character, row, column
//  result    rsp_valid / rsp_stall   cursor_row, cursor_column, cell_*,
//                                    scrolled
//  config    cfg_write               cfg_index, cfg_data
//
// sequencing: a put of a plain character or a set cursor goes straight from
//   the start state to the result; a read adds a wait state for the registered
//   memory read; a newline writes each blanked cell up to the last column in
//   turn, a clear writes every cell of the grid in turn, and a scroll first
//   moves each cell below the header up a row (a read, then a write), then
//   blanks the bottom row, then writes the character, all one cell at a time
// the first command after a write of columns or rows first passes the clamp
//   step and the 5-step row/column divider of the cursor
// reset: asynchronous, clears cursor, registers and handshake state; the
//   cell memory is not cleared
// stalls: the result register lets the next transfer in while a result
//   waits; a command stalls only in its final cycle while the result
//   register is still full
module text_console_cell_writer
    import tcw_pkg::*;
#(
    parameter int MAX_COLUMNS = 80,
    parameter int MAX_ROWS    = 25
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // command channel
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  logic [CMD_W-1:0]     command,
    input  logic [CHAR_W-1:0]    character,
    input  logic [ROW_W-1:0]     row,
    input  logic [COL_W-1:0]     column,
    // result channel
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic [ROW_W-1:0]     cursor_row,
    output logic [COL_W-1:0]     cursor_column,
    output logic [CHAR_W-1:0]    cell_character,
    output logic [COLOR_W-1:0]   cell_foreground,
    output logic [COLOR_W-1:0]   cell_background,
    output logic                 scrolled,
    // register writes
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    cfg_t       cfg;
    dp_cmd_t    dp_cmd;
    dp_status_t status;

    // registers with clamping to the supported grid
    tcw_cfg #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer: one datapath operation per cycle
    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .dp_cmd    (dp_cmd)
    );

    // cell memory, cursor and result register
    tcw_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .dp_cmd          (dp_cmd),
        .status          (status),
        .command         (command),
        .character       (character),
        .row             (row),
        .column          (column),
        .cursor_row      (cursor_row),
        .cursor_column   (cursor_column),
        .cell_character  (cell_character),
        .cell_foreground (cell_foreground),
        .cell_background (cell_background),
        .scrolled        (scrolled)
    );

    // one command in flight: an accepted transfer blocks the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("command accepted in back-to-back cycles");

    // a new result only follows a cycle of command processing
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(cmd_stall))
        else $error("result appeared without a command in progress");

    // only a put scrolls, and a put returns no cell contents
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && scrolled |->
            cell_character == '0 && cell_foreground == '0 && cell_background == '0)
        else $error("scroll reported with cell data");

endmodule

// ----- tb/sv/text_console_cell_writer_tb.sv -----
// text_console_cell_writer_tb: self-checking testbench for the console cell writer
// predicts every result from its own copy of the grid, cursor and registers
// depends on tcw_pkg and text_console_cell_writer
`timescale 1ns / 1ps

module text_console_cell_writer_tb
    import tcw_pkg::*;
();

    localparam int  MAX_COLUMNS   = 80;
    localparam int  MAX_ROWS      = 25;
    localparam int  GRID_CELLS    = MAX_COLUMNS * MAX_ROWS;
    localparam int  CLK_PERIOD    = 12;
    localparam int  SETTLE_CYCLES = 8;
    localparam int  DRAIN_CYCLES  = 20;
    localparam int  CYCLE_LIMIT   = 4000000;
    localparam int  SMALL_ITEMS   = 140;
    localparam int  LARGE_ITEMS   = 60;
    localparam int  RANDOM_PHASES = 13;

    // one result transfer, field for field
    typedef struct packed {
        logic [ROW_W-1:0]   cur_row;
        logic [COL_W-1:0]   cur_col;
        logic [CHAR_W-1:0]  chr;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        logic               scroll;
    } console_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cmd_valid = 1'b0;
    logic                 cmd_stall;
    logic [CMD_W-1:0]     command = CMD_PUT;
    logic [CHAR_W-1:0]    character = '0;
    logic [ROW_W-1:0]     row = '0;
    logic [COL_W-1:0]     column = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    logic [ROW_W-1:0]     cursor_row;
    logic [COL_W-1:0]     cursor_column;
    logic [CHAR_W-1:0]    cell_character;
    logic [COLOR_W-1:0]   cell_foreground;
    logic [COLOR_W-1:0]   cell_background;
    logic                 scrolled;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_COLUMNS;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    // predictor state: grid contents, which cells hold defined data, cursor, registers
    logic [CELL_W-1:0]  screen_model [GRID_CELLS];
    bit                 cell_written [GRID_CELLS];
    int                 cursor_pos;
    logic [COL_W-1:0]   reg_columns;
    logic [ROW_W-1:0]   reg_rows;
    logic [ROW_W-1:0]   reg_header;
    logic [COLOR_W-1:0] reg_fg;
    logic [COLOR_W-1:0] reg_bg;

    // results predicted but not yet seen on the result channel
    console_result_t pending_results [$];

    int cycle_count     = 0;
    int mismatches      = 0;
    int commands_sent   = 0;
    int results_checked = 0;
    int scrolls_seen    = 0;
    int input_held_off  = 0;
    int settings_used   = 0;
    int burst_left      = 0;
    int receiver_hold   = 0;
    int stall_tick      = 0;
    logic [7:0] stall_pattern = 8'h00;

    text_console_cell_writer uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_stall       (cmd_stall),
        .command         (command),
        .character       (character),
        .row             (row),
        .column          (column),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .cursor_row      (cursor_row),
        .cursor_column   (cursor_column),
        .cell_character  (cell_character),
        .cell_foreground (cell_foreground),
        .cell_background (cell_background),
        .scrolled        (scrolled),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: long hold-off when asked, otherwise an 8-bit stall pattern that is
    // redrawn whenever its countdown runs out (all-clear stretches included)
    always @(posedge clk)
    begin
        if (receiver_hold > 0)
        begin
            rsp_stall <= 1'b1;
            receiver_hold--;
        end
        else
        begin
            if (stall_tick == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pattern = 8'h00;
                    1:       stall_pattern = 8'h01;
                    2:       stall_pattern = 8'hB6;
                    default: stall_pattern = 8'($urandom_range(0, 255));
                endcase
                stall_tick = 48;
            end
            stall_tick--;
            rsp_stall <= stall_pattern[stall_tick % 8];
        end
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // geometry as the block uses it: zero means one, oversize means the maximum
    function automatic int grid_columns();
        if (reg_columns == 0) return 1;
        if (reg_columns > MAX_COLUMNS) return MAX_COLUMNS;
        return int'(reg_columns);
    endfunction

    function automatic int grid_rows();
        if (reg_rows == 0) return 1;
        if (reg_rows > MAX_ROWS) return MAX_ROWS;
        return int'(reg_rows);
    endfunction

    // linear cell address with row and column saturated to the grid
    function automatic int cell_address(input int r, input int c);
        int ncol;
        int nrow;
        ncol = grid_columns();
        nrow = grid_rows();
        if (r >= nrow) r = nrow - 1;
        if (c >= ncol) c = ncol - 1;
        return r * ncol + c;
    endfunction

    function automatic logic [CELL_W-1:0] styled_cell(input logic [CHAR_W-1:0] ch);
        return {reg_bg, reg_fg, ch};
    endfunction

    function automatic void blank_span(input int first, input int stop);
        for (int i = first; i < stop; i++)
        begin
            screen_model[i] = styled_cell(CHAR_SPACE);
            cell_written[i] = 1'b1;
        end
    endfunction

    function automatic console_result_t predict_console(input logic [CMD_W-1:0] cmd,
                                                        input logic [CHAR_W-1:0] ch,
                                                        input logic [ROW_W-1:0] r,
                                                        input logic [COL_W-1:0] c);
        console_result_t   res;
        logic [CELL_W-1:0] cell_val;
        int                ncol;
        int                nrow;
        int                grid_end;
        int                top;
        int                stop;
        ncol     = grid_columns();
        nrow     = grid_rows();
        grid_end = ncol * nrow;
        res      = '0;
        cell_val = '0;
        // grid may have shrunk under the cursor
        if (cursor_pos > grid_end) cursor_pos = grid_end;
        case (cmd)
            CMD_PUT:
            begin
                if (cursor_pos >= grid_end)
                begin
                    // one-line scroll below the header rows, bottom row blanked
                    top = int'(reg_header);
                    if (top > nrow - 1) top = nrow - 1;
                    for (int i = top * ncol; i + ncol < grid_end; i++)
                    begin
                        screen_model[i] = screen_model[i + ncol];
                        cell_written[i] = cell_written[i + ncol];
                    end
                    blank_span(grid_end - ncol, grid_end);
                    cursor_pos = grid_end - ncol;
                    res.scroll = 1'b1;
                end
                if (ch == CHAR_NEWLINE)
                begin
                    stop = (cursor_pos / ncol + 1) * ncol;
                    blank_span(cursor_pos, stop);
                    cursor_pos = stop;
                end
                else
                begin
                    screen_model[cursor_pos] = styled_cell(ch);
                    cell_written[cursor_pos] = 1'b1;
                    cursor_pos++;
                end
            end
            CMD_SET:   cursor_pos = cell_address(r, c);
            CMD_CLEAR: blank_span(0, grid_end);
            default:   cell_val = screen_model[cell_address(r, c)];
        endcase
        res.cur_row = ROW_W'(cursor_pos / ncol);
        res.cur_col = COL_W'(cursor_pos % ncol);
        res.chr     = cell_val[CHAR_W-1:0];
        res.fg      = cell_val[CHAR_W +: COLOR_W];
        res.bg      = cell_val[CHAR_W + COLOR_W +: COLOR_W];
        return res;
    endfunction

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------

    task automatic note_mismatch(input string what, input console_result_t want,
                                 input console_result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("cycle %0d %s: expected row %0d col %0d char %h fg %0d bg %0d scr %0b,"
                     , cycle_count, what, want.cur_row, want.cur_col, want.chr, want.fg,
                     want.bg, want.scroll,
                     " got row %0d col %0d char %h fg %0d bg %0d scr %0b",
                     got.cur_row, got.cur_col, got.chr, got.fg, got.bg, got.scroll);
    endtask

    // outputs are stable mid-cycle; a transfer seen here completes at the next rising edge
    always @(negedge clk)
    begin : result_check
        console_result_t seen;
        console_result_t want;
        if (rst_n && cmd_valid && cmd_stall) input_held_off++;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            seen = {cursor_row, cursor_column, cell_character, cell_foreground,
                    cell_background, scrolled};
            if (pending_results.size() == 0)
                note_mismatch("result with nothing pending", '0, seen);
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (want.scroll) scrolls_seen++;
                if (seen.cur_row !== want.cur_row || seen.cur_col !== want.cur_col ||
                    seen.chr !== want.chr || seen.fg !== want.fg ||
                    seen.bg !== want.bg || seen.scroll !== want.scroll)
                    note_mismatch("result mismatch", want, seen);
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // offer one command and hold it until the transfer; stall is sampled mid-cycle
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                                input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
        bit taken;
        cmd_valid <= 1'b1;
        command   <= cmd;
        character <= ch;
        row       <= r;
        column    <= c;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !cmd_stall;
            if (taken) pending_results.push_back(predict_console(cmd, ch, r, c));
            @(posedge clk);
        end
        commands_sent++;
    endtask

    // sender bursts: count down the burst, then drop valid and idle with junk payload
    task automatic pace_sender(input bit with_gaps);
        if (!with_gaps) return;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            cmd_valid <= 1'b0;
            command   <= CMD_W'($urandom_range(0, 3));
            character <= CHAR_W'($urandom_range(0, 255));
            row       <= ROW_W'($urandom_range(0, 31));
            column    <= COL_W'($urandom_range(0, 127));
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
    endtask

    // drop valid and let every predicted result come back before touching registers
    task automatic wait_quiet();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DAT_W-1:0];
        @(posedge clk);
        case (idx)
            CFG_COLUMNS:    reg_columns = value[COL_W-1:0];
            CFG_ROWS:       reg_rows    = value[ROW_W-1:0];
            CFG_HEADER:     reg_header  = value[ROW_W-1:0];
            CFG_FOREGROUND: reg_fg      = value[COLOR_W-1:0];
            CFG_BACKGROUND: reg_bg      = value[COLOR_W-1:0];
            default:        ;
        endcase
    endtask

    // all five registers back to back, block idle
    task automatic program_console(input int cols, input int rws, input int hdr,
                                   input int fg, input int bg);
        write_register(CFG_COLUMNS, cols);
        write_register(CFG_ROWS, rws);
        write_register(CFG_HEADER, hdr);
        write_register(CFG_FOREGROUND, fg);
        write_register(CFG_BACKGROUND, bg);
        cfg_write <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // one random command; reads only ever target cells that hold defined data
    task automatic send_random_command(input bit big_grid);
        int                roll;
        int                ncol;
        int                nrow;
        int                tries;
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  r;
        logic [COL_W-1:0]  c;
        ncol = grid_columns();
        nrow = grid_rows();
        roll = $urandom_range(0, 99);
        ch   = CHAR_W'($urandom_range(0, 255));
        r    = ROW_W'($urandom_range(0, 31));
        c    = COL_W'($urandom_range(0, 127));
        if (roll < 52)
        begin
            cmd = CMD_PUT;
            if ($urandom_range(0, 7) == 0) ch = CHAR_NEWLINE;
        end
        else if (roll < 68)
        begin
            cmd = CMD_SET;
            case ($urandom_range(0, 2))
                0: ;    // raw field values, mostly out of range
                1:
                begin
                    r = ROW_W'($urandom_range(0, nrow - 1));
                    c = COL_W'($urandom_range(0, ncol - 1));
                end
                default:
                begin
                    // near the end of the grid so puts soon scroll
                    r = ROW_W'(nrow - 1);
                    c = COL_W'(ncol - 1 - $urandom_range(0, (ncol > 4) ? 3 : ncol - 1));
                end
            endcase
        end
        else if (roll < (big_grid ? 69 : 71))
            cmd = CMD_CLEAR;
        else
        begin
            cmd = CMD_READ;
            for (tries = 0; tries < 4 && !cell_written[cell_address(r, c)]; tries++)
            begin
                r = ROW_W'($urandom_range(0, nrow - 1));
                c = COL_W'($urandom_range(0, ncol - 1));
            end
            // nothing defined found: move the cursor there instead
            if (!cell_written[cell_address(r, c)]) cmd = CMD_SET;
        end
        send_command(cmd, ch, r, c);
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset geometry: write, newline, saturated cursor, scroll at the end of the grid
    task automatic test_basic_editing();
        send_command(CMD_CLEAR, 8'h00, 5'd0, 7'd0);
        send_command(CMD_PUT, 8'h41, 5'd0, 7'd0);
        send_command(CMD_PUT, 8'hFF, 5'd0, 7'd0);
        send_command(CMD_PUT, 8'h00, 5'd0, 7'd0);
        send_command(CMD_READ, 8'h00, 5'd0, 7'd0);
        send_command(CMD_READ, 8'h00, 5'd0, 7'd2);
        send_command(CMD_PUT, CHAR_NEWLINE, 5'd0, 7'd0);
        send_command(CMD_READ, 8'h00, 5'd0, 7'd79);
        send_command(CMD_SET, 8'h00, 5'd31, 7'd127);
        send_command(CMD_PUT, 8'h5A, 5'd0, 7'd0);
        // cursor now past the last cell: this put scrolls first
        send_command(CMD_PUT, 8'h42, 5'd0, 7'd0);
        send_command(CMD_READ, 8'h00, 5'd24, 7'd0);
        send_command(CMD_READ, 8'h00, 5'd23, 7'd79);
        send_command(CMD_READ, 8'hFF, 5'd31, 7'd127);
        send_command(CMD_SET, 8'h00, 5'd24, 7'd79);
        send_command(CMD_PUT, CHAR_NEWLINE, 5'd0, 7'd0);
        // newline at the end: scroll, then blank the whole bottom row
        send_command(CMD_PUT, CHAR_NEWLINE, 5'h1F, 7'h7F);
    endtask

    // zero and oversize registers, header beyond the grid, cursor pulled back
    task automatic test_register_extremes();
        wait_quiet();
        program_console(0, 0, 31, 0, 15);
        send_command(CMD_PUT, 8'h78, 5'd0, 7'd0);
        send_command(CMD_READ, 8'h00, 5'd31, 7'd127);
        send_command(CMD_PUT, CHAR_NEWLINE, 5'd0, 7'd0);
        wait_quiet();
        program_console(127, 31, 24, 5, 10);
        send_command(CMD_SET, 8'h00, 5'd24, 7'd79);
        send_command(CMD_PUT, 8'h7F, 5'd0, 7'd0);
        send_command(CMD_PUT, 8'h80, 5'd0, 7'd0);
        send_command(CMD_READ, 8'h00, 5'd24, 7'd0);
        send_command(CMD_READ, 8'h00, 5'd23, 7'd79);
    endtask

    // receiver holds off while the sender keeps offering, then a full drain and paced traffic
    task automatic test_backpressure();
        wait_quiet();
        program_console(8, 4, 1, 3, 12);
        send_command(CMD_CLEAR, 8'h00, 5'd0, 7'd0);
        receiver_hold = 300;
        repeat (24) send_random_command(1'b0);
        // pause until every outstanding result has arrived
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (24)
        begin
            send_random_command(1'b0);
            pace_sender(1'b1);
        end
    endtask

    // random traffic over many register settings, mostly small grids
    task automatic test_random_phases();
        bit big_grid;
        int cols;
        int rws;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            big_grid = (phase == 4 || phase == 10);
            wait_quiet();
            if (big_grid)
            begin
                cols = $urandom_range(0, 1) ? 80 : $urandom_range(70, 127);
                rws  = $urandom_range(0, 1) ? 25 : $urandom_range(20, 31);
            end
            else
            begin
                cols = $urandom_range(0, 16);
                rws  = $urandom_range(0, 8);
            end
            program_console(cols, rws, $urandom_range(0, rws + 1), $urandom_range(0, 15),
                            $urandom_range(0, 15));
            if ($urandom_range(0, 1))
                send_command(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)),
                             ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
            // every fourth phase runs with the sender never idling
            repeat (big_grid ? LARGE_ITEMS : SMALL_ITEMS)
            begin
                send_random_command(big_grid);
                pace_sender(phase % 4 != 2);
            end
        end
    endtask

    initial
    begin
        // predictor reset state matches the block's
        cursor_pos  = 0;
        reg_columns = RST_COLUMNS;
        reg_rows    = RST_ROWS;
        reg_header  = RST_HEADER;
        reg_fg      = RST_FOREGROUND;
        reg_bg      = RST_BACKGROUND;
        for (int i = 0; i < GRID_CELLS; i++)
        begin
            screen_model[i] = '0;
            cell_written[i] = 1'b0;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_editing();
        test_register_extremes();
        test_backpressure();
        test_random_phases();

        // drain, then give a stray extra result time to show up
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d commands over %0d register settings, %0d results checked",
                 commands_sent, settings_used, results_checked);
        $display("%0d scrolls, %0d cycles with the command input held off",
                 scrolls_seen, input_held_off);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_cfg.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/tcw_dp.sv
hw/rtl/text_console_cell_writer.sv
tb/sv/text_console_cell_writer_tb.sv
